FILE: rtl/kwt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwt_pkg: shared types and constants of the keyword tokenizer
// Lexer modes, token kind codes, keyword table and the result record.
// ----------------------------------------------------------------------------
package kwt_pkg;

    localparam int MAX_LEN = 256;
    localparam logic [7:0] CNT_MAX = 8'(MAX_LEN - 1);

    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_NUM  = 3'd1,
        MODE_WORD = 3'd2,
        MODE_STR  = 3'd3,
        MODE_OP   = 3'd4
    } t_mode;

    localparam logic [3:0] KIND_EOF   = 4'd0;
    localparam logic [3:0] KIND_NUM   = 4'd1;
    localparam logic [3:0] KIND_KW0   = 4'd2;
    localparam logic [3:0] KIND_IDENT = 4'd10;
    localparam logic [3:0] KIND_STR   = 4'd11;
    localparam logic [3:0] KIND_OP    = 4'd12;
    localparam logic [3:0] KIND_ERR   = 4'd13;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_LT    = 8'h3C;
    localparam logic [7:0] CHAR_GT    = 8'h3E;

    localparam int KW_NUM = 8;

    typedef logic [0:8][7:0] t_kw_word;

    // padding characters beyond each keyword length are never compared
    localparam t_kw_word KW_TEXT [KW_NUM] = '{
        "iniciar  ", "finalizar", "mostrar  ", "repetir  ",
        "veces    ", "si       ", "entonces ", "sino     "
    };
    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd7, 4'd9, 4'd7, 4'd7, 4'd5, 4'd2, 4'd8, 4'd4
    };

    typedef struct packed {
        logic       kind;
        logic [7:0] ch;
        logic [3:0] tk;
        logic [7:0] len;
        logic       last;
    } t_result;

    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     item;
    } t_batch;

    function automatic t_result mk_value(input logic [7:0] c);
        t_result r;
        r      = '0;
        r.kind = 1'b0;
        r.ch   = c;
        return r;
    endfunction

    function automatic t_result mk_end(input logic [3:0] tk, input logic [7:0] len);
        t_result r;
        r      = '0;
        r.kind = 1'b1;
        r.tk   = tk;
        r.len  = len;
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/kwt_lexer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwt_lexer: lexer state and per-byte result generation
// Holds mode, value count and keyword match mask; forms the 0..3 results
// that one source byte causes.
// ----------------------------------------------------------------------------
module kwt_lexer
    import kwt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_char,
    output t_batch          o_batch
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_cnt, n_cnt;
    logic [7:0] r_alive, n_alive;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_op(input logic [7:0] c);
        return (c == CHAR_EQ) || (c == CHAR_BANG) || (c == CHAR_LT) || (c == CHAR_GT);
    endfunction

    function automatic logic [7:0] kw_filter(input logic [7:0] alive,
                                             input logic [7:0] cnt,
                                             input logic [7:0] c);
        logic [7:0] a;
        a = alive;
        for (int k = 0; k < KW_NUM; k++) begin
            if (cnt >= {4'd0, KW_LEN[k]}) begin
                a[k] = 1'b0;
            end else if (KW_TEXT[k][cnt[3:0]] != c) begin
                a[k] = 1'b0;
            end
        end
        return a;
    endfunction

    // start of a new token from idle
    t_mode      st_mode;
    logic [7:0] st_cnt;
    logic [7:0] st_alive;
    logic [1:0] st_n;
    t_result    st_r0, st_r1;

    always_comb begin
        st_mode  = MODE_IDLE;
        st_cnt   = 8'd0;
        st_alive = 8'hFF;
        st_n     = 2'd0;
        st_r0    = '0;
        st_r1    = '0;
        if (is_space(i_char)) begin
            st_n = 2'd0;
        end else if (i_char == CHAR_NUL) begin
            st_n  = 2'd1;
            st_r0 = mk_end(KIND_EOF, 8'd0);
        end else if (is_digit(i_char)) begin
            st_mode = MODE_NUM;
            st_cnt  = 8'd1;
            st_n    = 2'd1;
            st_r0   = mk_value(i_char);
        end else if (is_alpha(i_char)) begin
            st_mode  = MODE_WORD;
            st_cnt   = 8'd1;
            st_alive = kw_filter(8'hFF, 8'd0, i_char);
            st_n     = 2'd1;
            st_r0    = mk_value(i_char);
        end else if (i_char == CHAR_QUOTE) begin
            st_mode = MODE_STR;
        end else if (is_op(i_char)) begin
            st_mode = MODE_OP;
            st_cnt  = 8'd1;
            st_n    = 2'd1;
            st_r0   = mk_value(i_char);
        end else begin
            st_n  = 2'd2;
            st_r0 = mk_value(i_char);
            st_r1 = mk_end(KIND_ERR, 8'd1);
        end
    end

    // extend the open token
    logic [7:0] ap_alive;
    logic       ap_send;
    logic [7:0] ap_cnt;

    always_comb begin
        ap_alive = (r_mode == MODE_WORD) ? kw_filter(r_alive, r_cnt, i_char) : r_alive;
        ap_send  = r_cnt < CNT_MAX;
        ap_cnt   = r_cnt + {7'd0, ap_send};
    end

    logic [3:0] word_kind;

    always_comb begin
        word_kind = KIND_IDENT;
        for (int k = KW_NUM - 1; k >= 0; k--) begin
            if (r_alive[k] && (r_cnt == {4'd0, KW_LEN[k]})) begin
                word_kind = KIND_KW0 + 4'(k);
            end
        end
    end

    logic       has_pre, take_append, has_post, take_start, do_clear;
    t_result    pre, post;
    logic [1:0] idx;
    t_result [2:0] res;

    always_comb begin
        has_pre     = 1'b0;
        take_append = 1'b0;
        has_post    = 1'b0;
        take_start  = 1'b0;
        do_clear    = 1'b0;
        pre         = '0;
        post        = '0;
        unique case (r_mode)
            MODE_NUM: begin
                if (is_digit(i_char)) begin
                    take_append = 1'b1;
                end else begin
                    has_pre    = 1'b1;
                    pre        = mk_end(KIND_NUM, r_cnt);
                    take_start = 1'b1;
                end
            end
            MODE_WORD: begin
                if (is_alpha(i_char)) begin
                    take_append = 1'b1;
                end else begin
                    has_pre    = 1'b1;
                    pre        = mk_end(word_kind, r_cnt);
                    take_start = 1'b1;
                end
            end
            MODE_STR: begin
                if (i_char == CHAR_QUOTE) begin
                    has_pre  = 1'b1;
                    pre      = mk_end(KIND_STR, r_cnt);
                    do_clear = 1'b1;
                end else if (i_char == CHAR_NUL) begin
                    // unterminated string closes as an error token
                    has_pre    = 1'b1;
                    pre        = mk_end(KIND_ERR, r_cnt);
                    take_start = 1'b1;
                end else begin
                    take_append = 1'b1;
                end
            end
            MODE_OP: begin
                if (i_char == CHAR_EQ) begin
                    take_append = 1'b1;
                    has_post    = 1'b1;
                    post        = mk_end(KIND_OP, ap_cnt);
                    do_clear    = 1'b1;
                end else begin
                    has_pre    = 1'b1;
                    pre        = mk_end(KIND_OP, r_cnt);
                    take_start = 1'b1;
                end
            end
            default: begin
                take_start = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        n_alive = r_alive;
        res     = '0;
        idx     = 2'd0;
        if (has_pre) begin
            res[idx] = pre;
            idx      = idx + 2'd1;
        end
        if (take_append) begin
            n_cnt   = ap_cnt;
            n_alive = ap_alive;
            if (ap_send) begin
                res[idx] = mk_value(i_char);
                idx      = idx + 2'd1;
            end
        end
        if (has_post) begin
            res[idx] = post;
            idx      = idx + 2'd1;
        end
        if (take_start) begin
            n_mode  = st_mode;
            n_cnt   = st_cnt;
            n_alive = st_alive;
            if (st_n != 2'd0) begin
                res[idx] = st_r0;
                idx      = idx + 2'd1;
            end
            if (st_n == 2'd2) begin
                res[idx] = st_r1;
                idx      = idx + 2'd1;
            end
        end
        if (do_clear) begin
            n_mode  = MODE_IDLE;
            n_cnt   = 8'd0;
            n_alive = 8'hFF;
        end
        for (int i = 0; i < 3; i++) begin
            res[i].last = (idx != 2'd0) && (2'(i) == (idx - 2'd1));
        end
        o_batch.count = idx;
        o_batch.item  = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_cnt   <= 8'd0;
            r_alive <= 8'hFF;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_cnt   <= n_cnt;
            r_alive <= n_alive;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/kwt_result_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kwt_result_queue: four-slot result register
// Takes up to three results of one item at once, sends one per ready cycle.
// ----------------------------------------------------------------------------
module kwt_result_queue
    import kwt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_batch  i_batch,
    input  wire logic    i_out_ready,
    output logic         o_in_ready,
    output logic         o_out_valid,
    output t_result      o_head
);

    t_result    r_q [4];
    t_result    n_q [4];
    logic [2:0] r_cnt, n_cnt;
    logic       pop;
    logic [2:0] base;

    always_comb begin
        pop  = (r_cnt != 3'd0) && i_out_ready;
        base = r_cnt - {2'd0, pop};
        n_q  = r_q;
        if (pop) begin
            for (int i = 0; i < 3; i++) begin
                n_q[i] = r_q[i + 1];
            end
        end
        if (i_push) begin
            for (int j = 0; j < 3; j++) begin
                if (2'(j) < i_batch.count) begin
                    n_q[base[1:0] + 2'(j)] = i_batch.item[j];
                end
            end
        end
        n_cnt = base + (i_push ? {1'b0, i_batch.count} : 3'd0);
    end

    assign o_in_ready  = r_cnt <= 3'd1;
    assign o_out_valid = r_cnt != 3'd0;
    assign o_head      = r_q[0];

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/keyword_tokenizer_unit.sv
// Results are registered in the result queue before they are offered.
// Throughput: one byte per cycle while the output is ready and each byte
// causes at most one result; a byte causing more stalls input until one is left.
// The four-slot result register takes a byte whenever it holds at most one result.
// Reset (synchronous, active low) empties the results and returns the lexer
// to idle with no open token.
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_tokenizer_unit: streaming keyword tokenizer
// One source byte in per item; value characters and token ends out.
// ----------------------------------------------------------------------------
module keyword_tokenizer_unit
    import kwt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_char_in,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic            o_result_kind,
    output logic [7:0]      o_value_char,
    output logic [3:0]      o_token_kind,
    output logic [7:0]      o_token_length,
    output logic            o_last
);

    logic    accept;
    t_batch  batch;
    t_result head;

    assign accept = i_in_valid && o_in_ready;

    kwt_lexer u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_char_in),
        .o_batch  (batch)
    );

    kwt_result_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_batch     (batch),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_head      (head)
    );

    assign o_result_kind  = head.kind;
    assign o_value_char   = head.ch;
    assign o_token_kind   = head.tk;
    assign o_token_length = head.len;
    assign o_last         = head.last;

endmodule
`default_nettype wire
